@@ sv/longest_ones_window_k_flips_macros.svh @@
// Assertion macros shared by the checker of the longest-ones window block.
// Depends on nothing; included by the checker file only.
`ifndef LONGEST_ONES_WINDOW_K_FLIPS_MACROS_SVH
`define LONGEST_ONES_WINDOW_K_FLIPS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LOWK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lowk assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define LOWK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lowk assertion failed: next-cycle implication");

`endif

@@ sv/lowk_pkg.sv @@
// Package for the longest-ones window block: sizes, payload types and helpers.
// Depends on nothing; used by the interfaces, the cells, the output buffer and the top level.
package lowk_pkg;

    localparam int MAX_FLIPS = 15;
    localparam int MAX_LEN   = 65535;

    localparam int CFG_W = 4;
    localparam int LEN_W = 16;
    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int LIM_W = $clog2(MAX_FLIPS + 1);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LIM_W-1:0] lim_t;
    typedef logic [CFG_W-1:0] cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic             is_final;
        logic             overflow;
    } result_t;

    // A limit above the number of cells acts as the number of cells.
    function automatic lim_t clamp_limit(input cfg_t cfg);
        int v;
        v = int'(cfg);
        return (v > MAX_FLIPS) ? LIM_W'(MAX_FLIPS) : LIM_W'(v);
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input pos_t len);
        int unsigned v;
        v = int'(len);
        return (v > ((1 << LEN_W) - 1)) ? {LEN_W{1'b1}} : LEN_W'(v);
    endfunction

endpackage

@@ sv/lowk_ifs.sv @@
// Valid/ready channel interfaces for the input bits and the result items.
// Depends on lowk_pkg for the result field width.
interface lowk_in_if;
    logic valid;
    logic ready;
    logic bit_value;
    logic last_item;

    modport source (output valid, output bit_value, output last_item, input ready);
    modport sink (input valid, input bit_value, input last_item, output ready);
endinterface

interface lowk_out_if;
    logic                          valid;
    logic                          ready;
    logic [lowk_pkg::LEN_W-1:0]    best_length;
    logic                          is_final;
    logic                          overflow;

    modport source (output valid, output best_length, output is_final, output overflow,
                    input ready);
    modport sink (input valid, input best_length, input is_final, input overflow,
                  output ready);
endinterface

@@ sv/lowk_cell.sv @@
// One cell of the zero-position chain: holds the position of one zero in the window.
// Depends on lowk_pkg; a row of these cells is built by the top level.
module lowk_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lowk_pkg::cell_ctrl_t ctrl,
    input  logic                keep,
    input  lowk_pkg::pos_t      prev_pos,
    input  logic                prev_valid,
    output lowk_pkg::pos_t      pos,
    output logic                valid
);
    import lowk_pkg::*;

    pos_t pos_reg;
    logic valid_reg;
    logic valid_next;

    // A new zero pushes every entry one cell along; entries past the limit fall off.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = prev_valid && keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            pos_reg <= prev_pos;
        end
    end

    assign pos   = pos_reg;
    assign valid = valid_reg;

endmodule

@@ sv/lowk_skid.sv @@
// Two-entry output buffer (output register plus skid register) for result items.
// Depends on lowk_pkg and lowk_out_if.
module lowk_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lowk_pkg::result_t push_data,
    output logic              can_push,
    lowk_out_if.source        out_ch
);
    import lowk_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop      = out_valid_reg && out_ch.ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.best_length = out_data_reg.best_length;
    assign out_ch.is_final    = out_data_reg.is_final;
    assign out_ch.overflow    = out_data_reg.overflow;

endmodule

@@ sv/longest_ones_window_k_flips.sv @@
// Top level of the longest-ones window block: window state, cell chain and output buffer.
// Depends on lowk_pkg, lowk_ifs, lowk_cell and lowk_skid.
//
// Usage: bits arrive one item at a time on in_ch (bit_value, last_item). Every accepted
// item gives exactly one result item on out_ch: the longest window seen so far in this
// sequence that holds at most max_flips zeros, the item's last flag as is_final, and a
// sticky overflow flag once the sequence runs past MAX_LEN items.
// max_flips is written through cfg_we/cfg_wdata only while the block is idle, a rule for
// the user that the block does not enforce; it resets to 0. Throughput is one item per
// cycle while in_ch.ready is high: the window update is one pass through a chain of
// MAX_FLIPS cells that shift on each zero, plus one subtract and compare. A result is
// registered in the output register, which is backed by a skid register, so an item
// is still taken while one result waits; in_ch.ready is low only while the skid register
// holds a result, which needs a receiver stall with the output register already full.
// Reset clears the sequence state and the limit; after a last item the sequence state
// clears on its own and the next item starts a new sequence.
module longest_ones_window_k_flips (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  lowk_pkg::cfg_t      cfg_wdata,
    lowk_in_if.sink             in_ch,
    lowk_out_if.source          out_ch
);
    import lowk_pkg::*;

    cfg_t       max_flips_reg;
    pos_t       pos_reg;
    pos_t       ws_reg;
    pos_t       best_reg;
    logic       ovf_reg;

    pos_t       ws_next;
    pos_t       best_next;
    pos_t       len;
    pos_t       pos_inc;
    pos_t       hit_pos;
    logic       hit;
    logic       ovf_hit;
    logic       accept;
    logic       can_push;
    lim_t       limit;
    cell_ctrl_t ctrl;
    result_t    res;

    pos_t       cell_pos   [MAX_FLIPS];
    logic       cell_valid [MAX_FLIPS];
    logic       keep       [MAX_FLIPS];

    assign in_ch.ready = can_push;
    assign accept      = in_ch.valid && can_push;
    assign limit       = clamp_limit(max_flips_reg);
    assign ovf_hit     = (pos_reg == POS_W'(MAX_LEN));
    assign pos_inc     = pos_reg + POS_W'(1);

    assign ctrl.shift = accept && !in_ch.bit_value && !ovf_hit;
    assign ctrl.clear = accept && in_ch.last_item;

    // Cell 0 takes the current position; cell i keeps its entry only while i is below the limit.
    for (genvar i = 0; i < MAX_FLIPS; i++)
    begin : g_cell
        assign keep[i] = (limit > LIM_W'(i));
        if (i == 0)
        begin : g_head
            lowk_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .keep       (keep[i]),
                .prev_pos   (pos_reg),
                .prev_valid (1'b1),
                .pos        (cell_pos[i]),
                .valid      (cell_valid[i])
            );
        end
        else
        begin : g_body
            lowk_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .keep       (keep[i]),
                .prev_pos   (cell_pos[i-1]),
                .prev_valid (cell_valid[i-1]),
                .pos        (cell_pos[i]),
                .valid      (cell_valid[i])
            );
        end
    end

    // The zero at place limit-1 (newest first) is the last one dropped when a new zero
    // arrives with the window full; the window then starts just past it.
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < MAX_FLIPS; i++)
        begin
            if (cell_valid[i] && (limit == LIM_W'(i + 1)))
            begin
                hit     = 1'b1;
                hit_pos = cell_pos[i];
            end
        end
    end

    always_comb
    begin
        ws_next = ws_reg;
        if (!in_ch.bit_value)
        begin
            if (limit == '0)
            begin
                ws_next = pos_inc;
            end
            else if (hit)
            begin
                ws_next = hit_pos + POS_W'(1);
            end
        end
        len       = pos_inc - ws_next;
        best_next = (len > best_reg) ? len : best_reg;
    end

    assign res.best_length = ovf_hit ? sat_len(best_reg) : sat_len(best_next);
    assign res.is_final    = in_ch.last_item;
    assign res.overflow    = ovf_reg || ovf_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_flips_reg <= '0;
        end
        else if (cfg_we)
        begin
            max_flips_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ws_reg   <= '0;
            best_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (in_ch.last_item)
            begin
                pos_reg  <= '0;
                ws_reg   <= '0;
                best_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (ovf_hit)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                pos_reg  <= pos_inc;
                ws_reg   <= ws_next;
                best_reg <= best_next;
            end
        end
    end

    lowk_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .out_ch    (out_ch)
    );

endmodule

@@ sv/lowk_chk.sv @@
// Port-level checker for the longest-ones window block, bound to the top level.
// Depends on lowk_pkg and the assertion macros header.
`include "longest_ones_window_k_flips_macros.svh"

module lowk_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lowk_pkg::LEN_W-1:0] out_best_length,
    input logic                       out_is_final,
    input logic                       out_overflow
);
    import lowk_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // A stalled result stays offered and unchanged.
    `LOWK_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_best_length) && $stable(out_is_final) && $stable(out_overflow))

    // An item taken while no result is pending shows up as a result in the next cycle.
    `LOWK_ASSERT_NXT(a_one_cycle, clk, rst_n, in_acc && !out_valid, out_valid)

    // Input backpressure only happens while a result is waiting at the output.
    `LOWK_ASSERT_IMP(a_ready_cause, clk, rst_n, !in_ready, out_valid)

    // Once both buffer entries are full, a stalled receiver keeps the input closed.
    `LOWK_ASSERT_NXT(a_full_stall, clk, rst_n, !in_ready && !out_ready, !in_ready)

endmodule

bind longest_ones_window_k_flips lowk_chk u_lowk_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_best_length (out_ch.best_length),
    .out_is_final    (out_ch.is_final),
    .out_overflow    (out_ch.overflow)
);
